### src/ffba_pkg.sv
`default_nettype none

package ffba_pkg;

	// Table geometry and block layout.
	localparam int unsigned MAX_BLOCKS   = 64;
	localparam int unsigned HEADER_BYTES = 8;
	localparam int unsigned PAD_BYTES    = 4;

	localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
	localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);

	// One table entry in the block RAM: used mark, then header address, then payload length.
	localparam int unsigned ENTRY_W = 65;

	localparam logic [31:0] HEAP_START_RST = 32'h0010_0000;
	localparam logic [31:0] HEAP_LIMIT_RST = 32'h003E_0000;

	localparam logic [31:0] HEADER_W32 = 32'(HEADER_BYTES);
	localparam logic [31:0] EXTRA_W32  = 32'(HEADER_BYTES + PAD_BYTES);
	localparam logic [33:0] EXTRA_W34  = 34'(HEADER_BYTES + PAD_BYTES);

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_NEW     = 3'd0,
		ST_REUSED  = 3'd1,
		ST_FREED   = 3'd2,
		ST_IGNORED = 3'd3,
		ST_NOMEM   = 3'd4
	} status_t;

	typedef enum logic {
		REG_HEAP_START = 1'b0,
		REG_HEAP_LIMIT = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SCAN   = 3'b010,
		S_DECIDE = 3'b100
	} state_t;

endpackage

`default_nettype wire

### src/ffba_ram.sv
`default_nettype none

// Simple dual-port RAM with one write port and a registered read port.
module ffba_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### src/first_fit_block_allocator_core.sv
`default_nettype none

// A zero-size allocation or a null free is answered straight from idle; with an empty table
// the request goes straight to the decide state; otherwise the scan reads one table entry
// per cycle until a hit or the last entry, then goes to the decide state, which strobes done.
// One request is in flight at a time and the next is taken while the result strobes, so a
// request occupies the block until its result strobes; the receiver cannot stall the result.
// Reset (arst_n low) empties the table, restores both heap registers and clears the count.
module first_fit_block_allocator_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Request channel.
	input  wire logic        start,
	output logic             busy,
	input  wire logic        operation,
	input  wire logic [31:0] request_size,
	input  wire logic [31:0] payload_address,
	// Result channel: one strobe per request, no back pressure.
	output logic             done,
	output logic [2:0]       status,
	output logic [31:0]      result_address,
	output logic [31:0]      bytes_in_use,
	// Configuration write channel.
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data
);

	localparam int unsigned IDX_W = ffba_pkg::IDX_W;
	localparam int unsigned CNT_W = ffba_pkg::CNT_W;

	// Configuration registers.
	logic [31:0] heap_start_q;
	logic [31:0] heap_limit_q;

	// Allocator state that is not in the block RAM.
	logic [CNT_W-1:0] block_count_q;
	logic [31:0]      bump_q;
	logic [31:0]      charged_q;

	ffba_pkg::state_t state_q;

	// The request being served.
	logic [31:0] req_size_q;
	logic [31:0] req_addr_q;
	logic        req_op_q;

	// Scan read pointer and the compare stage that sees the RAM data.
	logic [IDX_W-1:0] rd_idx_q;
	logic             issue_more_q;
	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;

	// What the scan found.
	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic [31:0]      hit_start_q;
	logic [31:0]      hit_len_q;
	logic             hit_used_q;

	// Result registers.
	logic        done_q;
	logic [2:0]  status_q;
	logic [31:0] result_addr_q;
	logic [31:0] bytes_q;

	// Block RAM ports.
	logic                          ram_we;
	logic [IDX_W-1:0]              ram_waddr;
	logic [ffba_pkg::ENTRY_W-1:0]  ram_wdata;
	logic                          ram_re;
	logic [ffba_pkg::ENTRY_W-1:0]  ram_rdata;

	logic        accept;
	logic        trivial_ignore;
	logic        cfg_write;
	logic        scan_used;
	logic [31:0] scan_start;
	logic [31:0] scan_len;
	logic        alloc_match;
	logic        free_match;
	logic        scan_hit;
	logic        scan_last;
	logic [33:0] end_sum;
	logic        table_full;
	logic        no_room;
	logic        new_ok;
	logic        append;

	assign busy      = (state_q != ffba_pkg::S_IDLE);
	assign accept    = start && !busy;
	// Register writes wait until no request is in flight.
	assign cfg_ready = !busy;
	assign cfg_write = cfg_valid && cfg_ready;

	// A zero-size allocation or a free of address zero never touches the table.
	assign trivial_ignore =
		((operation == ffba_pkg::OP_ALLOC) && (request_size == 32'd0)) ||
		((operation == ffba_pkg::OP_FREE) && (payload_address == 32'd0));

	// The scan issues one read per cycle; the compare stage runs in the cycle after each read.
	assign ram_re = (state_q == ffba_pkg::S_SCAN) && issue_more_q;

	assign scan_used   = ram_rdata[64];
	assign scan_start  = ram_rdata[63:32];
	assign scan_len    = ram_rdata[31:0];
	assign alloc_match = !scan_used && (scan_len >= req_size_q);
	assign free_match  = ((scan_start + ffba_pkg::HEADER_W32) == req_addr_q);
	assign scan_hit    = vld_s1 &&
		((req_op_q == ffba_pkg::OP_FREE) ? free_match : alloc_match);
	assign scan_last   = vld_s1 && (CNT_W'(idx_s1) == (block_count_q - 1'b1));

	// New-block check: the end address is formed two bits wider so it cannot wrap.
	assign end_sum    = {2'b00, bump_q} + {2'b00, req_size_q} + ffba_pkg::EXTRA_W34;
	assign table_full = (block_count_q == CNT_W'(ffba_pkg::MAX_BLOCKS));
	assign no_room    = (end_sum >= {2'b00, heap_limit_q});
	assign new_ok     = !table_full && !no_room;

	// An append writes the new entry at the current end of the table. A reuse or a free
	// writes the found entry back with its used mark changed. The scan of the next request
	// starts only after this write, so no access to the same entry can overlap.
	assign append    = (state_q == ffba_pkg::S_DECIDE) && (req_op_q == ffba_pkg::OP_ALLOC) &&
		!hit_q && new_ok;
	assign ram_we    = append || ((state_q == ffba_pkg::S_DECIDE) && hit_q &&
		((req_op_q == ffba_pkg::OP_ALLOC) || hit_used_q));
	assign ram_waddr = hit_q ? hit_idx_q : block_count_q[IDX_W-1:0];
	assign ram_wdata = hit_q ? {(req_op_q == ffba_pkg::OP_ALLOC), hit_start_q, hit_len_q} :
		{1'b1, bump_q, req_size_q};

	ffba_ram #(
		.WIDTH(ffba_pkg::ENTRY_W),
		.DEPTH(ffba_pkg::MAX_BLOCKS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(rd_idx_q),
		.rdata(ram_rdata)
	);

	// Request and scan payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_op_q   <= operation;
			req_size_q <= request_size;
			req_addr_q <= payload_address;
		end
		idx_s1 <= rd_idx_q;
		if ((state_q == ffba_pkg::S_SCAN) && scan_hit) begin
			hit_idx_q   <= idx_s1;
			hit_start_q <= scan_start;
			hit_len_q   <= scan_len;
			hit_used_q  <= scan_used;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ffba_pkg::S_IDLE;
			heap_start_q  <= ffba_pkg::HEAP_START_RST;
			heap_limit_q  <= ffba_pkg::HEAP_LIMIT_RST;
			block_count_q <= '0;
			bump_q        <= ffba_pkg::HEAP_START_RST;
			charged_q     <= '0;
			rd_idx_q      <= '0;
			issue_more_q  <= 1'b0;
			vld_s1        <= 1'b0;
			hit_q         <= 1'b0;
			done_q        <= 1'b0;
			status_q      <= ffba_pkg::ST_IGNORED;
			result_addr_q <= '0;
			bytes_q       <= '0;
		end else begin
			done_q <= 1'b0;
			vld_s1 <= ram_re;

			// Configuration is only written while no request is in flight.
			if (cfg_write) begin
				unique case (ffba_pkg::reg_idx_t'(cfg_index))
					ffba_pkg::REG_HEAP_START: begin
						heap_start_q <= cfg_data;
						if (block_count_q == '0) begin
							bump_q <= cfg_data;
						end
					end
					ffba_pkg::REG_HEAP_LIMIT: begin
						heap_limit_q <= cfg_data;
					end
					default: begin
					end
				endcase
			end

			unique case (state_q)
				ffba_pkg::S_IDLE: begin
					if (accept) begin
						hit_q    <= 1'b0;
						rd_idx_q <= '0;
						if (trivial_ignore) begin
							// Answered right away; the table is not consulted.
							done_q        <= 1'b1;
							status_q      <= ffba_pkg::ST_IGNORED;
							result_addr_q <= '0;
							bytes_q       <= charged_q;
						end else if (block_count_q == '0) begin
							state_q <= ffba_pkg::S_DECIDE;
						end else begin
							issue_more_q <= 1'b1;
							state_q      <= ffba_pkg::S_SCAN;
						end
					end
				end
				ffba_pkg::S_SCAN: begin
					if (ram_re) begin
						if (CNT_W'(rd_idx_q) == (block_count_q - 1'b1)) begin
							issue_more_q <= 1'b0;
						end else begin
							rd_idx_q <= rd_idx_q + 1'b1;
						end
					end
					// The first matching entry wins; the rest of the scan is dropped.
					if (scan_hit) begin
						hit_q        <= 1'b1;
						issue_more_q <= 1'b0;
						state_q      <= ffba_pkg::S_DECIDE;
					end else if (scan_last) begin
						state_q <= ffba_pkg::S_DECIDE;
					end
				end
				ffba_pkg::S_DECIDE: begin
					done_q        <= 1'b1;
					result_addr_q <= '0;
					state_q       <= ffba_pkg::S_IDLE;
					if (req_op_q == ffba_pkg::OP_ALLOC) begin
						if (hit_q) begin
							// Reuse charges the whole block, never a split part.
							charged_q     <= charged_q + hit_len_q + ffba_pkg::EXTRA_W32;
							bytes_q       <= charged_q + hit_len_q + ffba_pkg::EXTRA_W32;
							result_addr_q <= hit_start_q + ffba_pkg::HEADER_W32;
							status_q      <= ffba_pkg::ST_REUSED;
						end else if (new_ok) begin
							block_count_q <= block_count_q + 1'b1;
							bump_q        <= end_sum[31:0];
							charged_q     <= charged_q + req_size_q + ffba_pkg::EXTRA_W32;
							bytes_q       <= charged_q + req_size_q + ffba_pkg::EXTRA_W32;
							result_addr_q <= bump_q + ffba_pkg::HEADER_W32;
							status_q      <= ffba_pkg::ST_NEW;
						end else begin
							bytes_q  <= charged_q;
							status_q <= ffba_pkg::ST_NOMEM;
						end
					end else begin
						// A free of a block that is already free is ignored.
						if (hit_q && hit_used_q) begin
							charged_q <= charged_q - (hit_len_q + ffba_pkg::EXTRA_W32);
							bytes_q   <= charged_q - (hit_len_q + ffba_pkg::EXTRA_W32);
							status_q  <= ffba_pkg::ST_FREED;
						end else begin
							bytes_q  <= charged_q;
							status_q <= ffba_pkg::ST_IGNORED;
						end
					end
				end
				default: begin
					state_q <= ffba_pkg::S_IDLE;
				end
			endcase
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign result_address = result_addr_q;
	assign bytes_in_use   = bytes_q;

`ifndef SYNTHESIS
	// A result only follows a decision or an immediate ignore.
	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(state_q) == ffba_pkg::S_DECIDE) || $past(accept))
		else $error("result strobe without a finished request");

	// Only granted blocks report a payload address.
	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && (status_q != ffba_pkg::ST_NEW) && (status_q != ffba_pkg::ST_REUSED)
		|-> (result_addr_q == '0))
		else $error("nonzero address on a request that granted nothing");

	// Every append grows the table by exactly one entry.
	a_append_count: assert property (@(posedge clk) disable iff (!arst_n)
		append |=> (block_count_q == $past(block_count_q) + 1'b1))
		else $error("table append without count increment");

	// The compare stage never looks past the valid part of the table.
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (CNT_W'(idx_s1) < block_count_q))
		else $error("scan read beyond the table end");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		block_count_q <= CNT_W'(ffba_pkg::MAX_BLOCKS))
		else $error("block count above table depth");
`endif

endmodule

`default_nettype wire
